// ----- rtl/cpjk_pkg.sv -----
package cpjk_pkg;

  localparam int unsigned POS_W      = 20;
  localparam int unsigned STICK_W    = 12;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DB_W       = 11;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned Q8_W       = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;

  // Jog product: signed stick times zero-extended gain.
  localparam int unsigned PROD_W     = STICK_W + GAIN_W + 1;
  // Fraction bits dropped from the product to get 1/256 mm.
  localparam int unsigned JOG_FRAC   = 8;
  // Squares, radicand (even width, room for the carry of the sum) and root.
  localparam int unsigned SQ_W       = 2 * POS_W;
  localparam int unsigned RAD_W      = 2 * POS_W + 2;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned ITER_W     = $clog2(ROOT_W + 1);
  // Length times steps per mm, with 16 fraction bits.
  localparam int unsigned STP_W      = ROOT_W + Q8_W;
  localparam int unsigned STEP_FRAC  = 16;
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  localparam int unsigned STEPS_PER_MM_M1_Q8_DEF = 20480;
  localparam int unsigned STEPS_PER_MM_M2_Q8_DEF = 20480;
  localparam int unsigned INIT_X_DEF             = 131072;
  localparam int unsigned INIT_Y_DEF             = 131072;

  localparam logic [GAIN_W-1:0] JOG_GAIN_RST      = 16'd256;
  localparam logic [DB_W-1:0]   DEADBAND_RST      = 11'd100;
  localparam logic [POS_W-1:0]  POS_MIN_RST       = 20'd0;
  localparam logic [POS_W-1:0]  POS_MAX_RST       = 20'hFFFFF;
  localparam logic [POS_W-1:0]  MOTOR_SPACING_RST = 20'd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JOG_GAIN      = 4'd0,
    CFG_DEADBAND_X    = 4'd1,
    CFG_DEADBAND_Y    = 4'd2,
    CFG_X_MIN         = 4'd3,
    CFG_X_MAX         = 4'd4,
    CFG_Y_MIN         = 4'd5,
    CFG_Y_MAX         = 4'd6,
    CFG_MOTOR_SPACING = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  pen_x;
    logic [POS_W-1:0]  pen_y;
    logic [STEP_W-1:0] left_steps;
    logic [STEP_W-1:0] right_steps;
  } out_t;

  typedef struct packed {
    logic lat_in;
    logic jog_mul;
    logic jog_upd;
    logic sq_a;
    logic sq_b;
    logic sqrt_go;
    logic len_a_cap;
    logic len_b_cap;
    logic step_mul;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } dp_sts_t;

endpackage

// ----- rtl/cpjk_isqrt.sv -----
module cpjk_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cpjk_pkg::RAD_W-1:0]     rad,
  output logic                           done,
  output logic [cpjk_pkg::ROOT_W-1:0]    root
);

  localparam int unsigned REM_W = cpjk_pkg::ROOT_W + 2;
  localparam int unsigned CUR_W = REM_W + 2;

  logic [cpjk_pkg::RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [cpjk_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [cpjk_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CUR_W-1:0]            cur;
  logic [CUR_W-1:0]            trial;

  // One result bit per cycle: bring down two radicand bits, try 4*root+1.
  always_comb begin
    cur      = {rem_r, rad_r[cpjk_pkg::RAD_W-1 -: 2]};
    trial    = {{(CUR_W - cpjk_pkg::ROOT_W - 2){1'b0}}, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = cpjk_pkg::ITER_W'(cpjk_pkg::ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[cpjk_pkg::RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_nxt  = REM_W'(cur - trial);
        root_nxt = {root_r[cpjk_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(cur);
        root_nxt = {root_r[cpjk_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == cpjk_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/cpjk_dpath.sv -----
module cpjk_dpath #(
  parameter int unsigned STEPS_PER_MM_M1_Q8 = cpjk_pkg::STEPS_PER_MM_M1_Q8_DEF,
  parameter int unsigned STEPS_PER_MM_M2_Q8 = cpjk_pkg::STEPS_PER_MM_M2_Q8_DEF,
  parameter int unsigned INIT_X             = cpjk_pkg::INIT_X_DEF,
  parameter int unsigned INIT_Y             = cpjk_pkg::INIT_Y_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpjk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpjk_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  cpjk_pkg::in_t                     in_data,
  input  cpjk_pkg::ctrl_cmd_t               cmd,
  output cpjk_pkg::dp_sts_t                 sts,
  output cpjk_pkg::out_t                    out_data
);

  localparam logic [cpjk_pkg::Q8_W-1:0]  Q1     = cpjk_pkg::Q8_W'(STEPS_PER_MM_M1_Q8);
  localparam logic [cpjk_pkg::Q8_W-1:0]  Q2     = cpjk_pkg::Q8_W'(STEPS_PER_MM_M2_Q8);
  localparam logic [cpjk_pkg::POS_W-1:0] X_INIT = cpjk_pkg::POS_W'(INIT_X);
  localparam logic [cpjk_pkg::POS_W-1:0] Y_INIT = cpjk_pkg::POS_W'(INIT_Y);

  logic [cpjk_pkg::GAIN_W-1:0] gain_r;
  logic [cpjk_pkg::DB_W-1:0]   dbx_r, dby_r;
  logic [cpjk_pkg::POS_W-1:0]  xmin_r, xmax_r, ymin_r, ymax_r, spacing_r;
  logic [cpjk_pkg::POS_W-1:0]  pos_x_r, pos_y_r, dx_r;
  cpjk_pkg::in_t               stick_r;
  logic signed [cpjk_pkg::PROD_W-1:0] prod_x_r, prod_y_r;
  logic [cpjk_pkg::SQ_W-1:0]   sq_r, y2_r;
  logic [cpjk_pkg::POS_W-1:0]  sq_op;
  logic [cpjk_pkg::RAD_W-1:0]  rad;
  logic [cpjk_pkg::ROOT_W-1:0] root;
  logic                        root_done;
  logic [cpjk_pkg::ROOT_W-1:0] len_a_r, len_b_r;
  logic [cpjk_pkg::STP_W-1:0]  st_a_r, st_b_r;
  cpjk_pkg::out_t              out_r;

  function automatic logic [cpjk_pkg::POS_W-1:0] jog_axis(
    input logic [cpjk_pkg::POS_W-1:0]          pos,
    input logic signed [cpjk_pkg::STICK_W-1:0] s,
    input logic [cpjk_pkg::DB_W-1:0]           db,
    input logic signed [cpjk_pkg::PROD_W-1:0]  prod,
    input logic [cpjk_pkg::POS_W-1:0]          lo,
    input logic [cpjk_pkg::POS_W-1:0]          hi
  );
    logic signed [cpjk_pkg::STICK_W:0]  s_e;
    logic signed [cpjk_pkg::STICK_W:0]  db_e;
    logic [cpjk_pkg::PROD_W-1:0]        mag;
    logic [cpjk_pkg::POS_W:0]           dmag;
    logic signed [cpjk_pkg::POS_W+1:0]  delta;
    logic signed [cpjk_pkg::POS_W+1:0]  nv;
    logic signed [cpjk_pkg::POS_W+1:0]  lo_e;
    logic signed [cpjk_pkg::POS_W+1:0]  hi_e;
    logic [cpjk_pkg::POS_W-1:0]         res;
    s_e  = {s[cpjk_pkg::STICK_W-1], s};
    db_e = $signed({{(cpjk_pkg::STICK_W + 1 - cpjk_pkg::DB_W){1'b0}}, db});
    mag  = prod[cpjk_pkg::PROD_W-1] ? cpjk_pkg::PROD_W'(-prod) : cpjk_pkg::PROD_W'(prod);
    dmag = (cpjk_pkg::POS_W + 1)'(mag >> cpjk_pkg::JOG_FRAC);
    // Division rounds toward zero, so the magnitude is shifted and the sign restored.
    delta = prod[cpjk_pkg::PROD_W-1] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    nv    = $signed({2'b00, pos}) + delta;
    lo_e  = $signed({2'b00, lo});
    hi_e  = $signed({2'b00, hi});
    res   = pos;
    if (s_e > db_e || s_e < -db_e) begin
      if (nv > hi_e) begin
        res = hi;
      end else if (nv < lo_e) begin
        res = lo;
      end else begin
        res = nv[cpjk_pkg::POS_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [cpjk_pkg::STEP_W-1:0] to_steps(
    input logic [cpjk_pkg::STP_W-1:0] st
  );
    logic [cpjk_pkg::STP_W-1:0] sh;
    sh = st >> cpjk_pkg::STEP_FRAC;
    if (sh > cpjk_pkg::STP_W'(cpjk_pkg::STEP_MAX)) begin
      return cpjk_pkg::STEP_MAX;
    end
    return cpjk_pkg::STEP_W'(sh);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= cpjk_pkg::JOG_GAIN_RST;
      dbx_r     <= cpjk_pkg::DEADBAND_RST;
      dby_r     <= cpjk_pkg::DEADBAND_RST;
      xmin_r    <= cpjk_pkg::POS_MIN_RST;
      xmax_r    <= cpjk_pkg::POS_MAX_RST;
      ymin_r    <= cpjk_pkg::POS_MIN_RST;
      ymax_r    <= cpjk_pkg::POS_MAX_RST;
      spacing_r <= cpjk_pkg::MOTOR_SPACING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cpjk_pkg::CFG_JOG_GAIN:      gain_r    <= cfg_data[cpjk_pkg::GAIN_W-1:0];
        cpjk_pkg::CFG_DEADBAND_X:    dbx_r     <= cfg_data[cpjk_pkg::DB_W-1:0];
        cpjk_pkg::CFG_DEADBAND_Y:    dby_r     <= cfg_data[cpjk_pkg::DB_W-1:0];
        cpjk_pkg::CFG_X_MIN:         xmin_r    <= cfg_data[cpjk_pkg::POS_W-1:0];
        cpjk_pkg::CFG_X_MAX:         xmax_r    <= cfg_data[cpjk_pkg::POS_W-1:0];
        cpjk_pkg::CFG_Y_MIN:         ymin_r    <= cfg_data[cpjk_pkg::POS_W-1:0];
        cpjk_pkg::CFG_Y_MAX:         ymax_r    <= cfg_data[cpjk_pkg::POS_W-1:0];
        cpjk_pkg::CFG_MOTOR_SPACING: spacing_r <= cfg_data[cpjk_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pen position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= X_INIT;
      pos_y_r <= Y_INIT;
    end else if (cmd.jog_upd) begin
      pos_x_r <= jog_axis(pos_x_r, stick_r.stick_x, dbx_r, prod_x_r, xmin_r, xmax_r);
      pos_y_r <= jog_axis(pos_y_r, stick_r.stick_y, dby_r, prod_y_r, ymin_r, ymax_r);
    end
  end

  // The square multiplier serves x first and then the anchor distance.
  assign sq_op = cmd.sq_b ? dx_r : pos_x_r;
  assign rad   = cpjk_pkg::RAD_W'(sq_r) + cpjk_pkg::RAD_W'(y2_r);

  cpjk_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_go),
    .rad   (rad),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.lat_in) begin
      stick_r <= in_data;
    end
    if (cmd.jog_mul) begin
      prod_x_r <= stick_r.stick_x * $signed({1'b0, gain_r});
      prod_y_r <= stick_r.stick_y * $signed({1'b0, gain_r});
    end
    if (cmd.sq_a) begin
      dx_r <= (spacing_r >= pos_x_r) ? spacing_r - pos_x_r : pos_x_r - spacing_r;
      y2_r <= pos_y_r * pos_y_r;
    end
    if (cmd.sq_a || cmd.sq_b) begin
      sq_r <= sq_op * sq_op;
    end
    if (cmd.len_a_cap) begin
      len_a_r <= root;
    end
    if (cmd.len_b_cap) begin
      len_b_r <= root;
    end
    if (cmd.step_mul) begin
      st_a_r <= len_a_r * Q1;
      st_b_r <= len_b_r * Q2;
    end
    if (cmd.out_load) begin
      out_r.pen_x       <= pos_x_r;
      out_r.pen_y       <= pos_y_r;
      out_r.left_steps  <= to_steps(st_a_r);
      out_r.right_steps <= to_steps(st_b_r);
    end
  end

  assign sts.sqrt_done = root_done;
  assign out_data      = out_r;

endmodule

// ----- rtl/cpjk_ctrl.sv -----
module cpjk_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  cpjk_pkg::dp_sts_t     sts,
  output cpjk_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JMUL,
    ST_JUPD,
    ST_SQA,
    ST_SQB,
    ST_ROOTA,
    ST_STARTB,
    ST_ROOTB,
    ST_SMUL,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.lat_in = 1'b1;
          state_nxt  = ST_JMUL;
        end
      end
      ST_JMUL: begin
        cmd.jog_mul = 1'b1;
        state_nxt   = ST_JUPD;
      end
      ST_JUPD: begin
        cmd.jog_upd = 1'b1;
        state_nxt   = ST_SQA;
      end
      ST_SQA: begin
        cmd.sq_a  = 1'b1;
        state_nxt = ST_SQB;
      end
      ST_SQB: begin
        cmd.sq_b    = 1'b1;
        cmd.sqrt_go = 1'b1;
        state_nxt   = ST_ROOTA;
      end
      ST_ROOTA: begin
        if (sts.sqrt_done) begin
          cmd.len_a_cap = 1'b1;
          state_nxt     = ST_STARTB;
        end
      end
      ST_STARTB: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = ST_ROOTB;
      end
      ST_ROOTB: begin
        if (sts.sqrt_done) begin
          cmd.len_b_cap = 1'b1;
          state_nxt     = ST_SMUL;
        end
      end
      ST_SMUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/cable_plotter_jog_kinematics_core.sv -----
// Joystick jog and cable kinematics for a two-motor hanging plotter. Each
// accepted input word is one joystick tick carrying signed X and Y readings.
// A reading whose magnitude exceeds its deadband moves the pen on that axis
// by reading times jog_gain (rounded toward zero to 1/256 mm), then clamps
// the position to the axis limits; the upper limit is checked first. The
// block then forms both cord lengths, floor(sqrt(x^2 + y^2)) to the left
// anchor at the origin and floor(sqrt((spacing - x)^2 + y^2)) to the right
// anchor, and scales each by the motor's steps per mm to a 24-bit step
// target, truncated and saturated. Each input word yields exactly one output
// word holding the new pen position and both step targets. After accepting
// a word the block forms the jog products, updates the position, forms the
// squares, takes both roots and scales them, then loads the result register;
// with the output free the next word can be accepted after that load. The two
// roots run one after the other on a single bit-serial root unit, each as a
// start, 21 iterations that produce one result bit per cycle, and a capture.
// The next tick is taken as soon as the result has been moved to the output
// register, even while that register still waits on out_stall.
// Configuration writes are always ready and should be made only while the
// block is idle; indexes beyond the last register are ignored.
module cable_plotter_jog_kinematics_core #(
  parameter int unsigned STEPS_PER_MM_M1_Q8 = cpjk_pkg::STEPS_PER_MM_M1_Q8_DEF,
  parameter int unsigned STEPS_PER_MM_M2_Q8 = cpjk_pkg::STEPS_PER_MM_M2_Q8_DEF,
  parameter int unsigned INIT_X             = cpjk_pkg::INIT_X_DEF,
  parameter int unsigned INIT_Y             = cpjk_pkg::INIT_Y_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cpjk_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cpjk_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpjk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpjk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cpjk_pkg::ctrl_cmd_t cmd;
  cpjk_pkg::dp_sts_t   sts;

  // The register file never backpressures a write.
  assign cfg_ready = 1'b1;

  // The controller sequences jog, squares, both roots and step scaling, and
  // owns the output valid flag.
  cpjk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds configuration, pen position, arithmetic and the
  // output payload register.
  cpjk_dpath #(
    .STEPS_PER_MM_M1_Q8 (STEPS_PER_MM_M1_Q8),
    .STEPS_PER_MM_M2_Q8 (STEPS_PER_MM_M2_Q8),
    .INIT_X             (INIT_X),
    .INIT_Y             (INIT_Y)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/cpjk_checker.sv -----
module cpjk_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input cpjk_pkg::in_t                     in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input cpjk_pkg::out_t                    out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // A result word waits while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

  // A stalled input word is held by the sender.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word dropped or changed while stalled");

  // One tick at a time: after accepting a word the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again before the tick finished");

  // A new result appears only as the block returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while the block is still busy");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind cable_plotter_jog_kinematics_core cpjk_checker u_cpjk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
